// ----- hdl/ipv4hb_pkg.sv -----
// Shared types and constants for the IPv4 header builder.
`default_nettype none
package ipv4hb_pkg;

   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [15:0] VerIhlTos = 16'h4500;
   localparam logic [15:0] IdentWord = 16'h0001;
   localparam logic [15:0] FlagsWord = 16'h4000;
   localparam logic [7:0]  TtlValue  = 8'h40;
   localparam logic [15:0] HdrBytes  = 16'd20;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_OWN_ADDRESS     = 2'd0,
      CSR_NET_MASK        = 2'd1,
      CSR_GATEWAY_ADDRESS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [31:0] own_address;
      logic [31:0] net_mask;
      logic [31:0] gateway_address;
   } cfg_type;

   typedef struct packed {
      logic [31:0] dest_address;
      logic [7:0]  protocol_number;
      logic [15:0] payload_length;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] header_word0;
      logic [31:0] header_word1;
      logic [31:0] header_word2;
      logic [31:0] header_word3;
      logic [31:0] header_word4;
      logic [31:0] next_hop;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- hdl/ipv4_header_builder_with_route.sv -----
// Top level of the IPv4 header builder with next-hop selection.
`default_nettype none
// Takes one request per cycle and returns, for each, the five words of a
// 20-byte IPv4 header (DF set, TTL 64, identification 1, source = own
// address, checksum filled in) and the next-hop address: the destination
// when it shares the own address's subnet, the gateway otherwise. rsp_valid
// rises once the request, accepted into the input register, has passed
// through one shallow checksum adder tree and mask compare and been caught
// in the result register; a stalled result can hold it in the input register.
// Throughput is one request per cycle while rsp_stall is low; req_stall
// rises only when both registers hold requests and the result is stalled.
// Configuration registers must be written while no request is in flight;
// csr_ready is always high and writes to index 3 are dropped.
module ipv4_header_builder_with_route (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire ipv4hb_pkg::req_payload_type          req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ipv4hb_pkg::rsp_payload_type               rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ipv4hb_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [31:0]                          csr_data
);
   import ipv4hb_pkg::*;

   cfg_type         cfg;
   req_payload_type in_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   rsp_payload_type hdr;
   rsp_payload_type out_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            out_load;
   logic            in_load;

   assign csr_ready = 1'b1;

   ipv4hb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipv4hb_hdr u_hdr (
      .req (in_ff),
      .cfg (cfg),
      .rsp (hdr)
   );

   always_comb begin
      out_load     = !out_valid_ff || !rsp_stall;
      in_load      = !in_valid_ff || out_load;
      req_stall    = !in_load;
      in_valid_in  = in_load ? req_valid : in_valid_ff;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_ff <= req_data;
      end
      if (out_load && in_valid_ff) begin
         out_ff <= hdr;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted request not held in input register");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_ident_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.header_word1 == {IdentWord, FlagsWord}))
      else $error("identification or flags word corrupted");

   a_next_hop_choice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.next_hop == rsp_data.header_word4)
                  || (rsp_data.next_hop == cfg.gateway_address)))
      else $error("next hop is neither destination nor gateway");
`endif

endmodule
`default_nettype wire

// ----- hdl/ipv4hb_csr.sv -----
// Configuration register file: own address, subnet mask, gateway.
`default_nettype none
module ipv4hb_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [ipv4hb_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [31:0]                         csr_data,
   output ipv4hb_pkg::cfg_type                      cfg
);
   import ipv4hb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OWN_ADDRESS:     cfg_in.own_address     = csr_data;
            CSR_NET_MASK:        cfg_in.net_mask        = csr_data;
            CSR_GATEWAY_ADDRESS: cfg_in.gateway_address = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/ipv4hb_hdr.sv -----
// Header word assembly, checksum adder tree and next-hop selection.
`default_nettype none
module ipv4hb_hdr (
   input  wire ipv4hb_pkg::req_payload_type req,
   input  wire ipv4hb_pkg::cfg_type         cfg,
   output ipv4hb_pkg::rsp_payload_type      rsp
);
   import ipv4hb_pkg::*;

   logic [15:0] total_len;
   logic [15:0] ttl_proto;
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] csum;
   logic        on_subnet;

   always_comb begin
      total_len = req.payload_length + HdrBytes;
      ttl_proto = {TtlValue, req.protocol_number};
      sum = 20'(VerIhlTos) + 20'(IdentWord) + 20'(FlagsWord) + 20'(ttl_proto)
          + 20'(total_len)
          + 20'(cfg.own_address[31:16]) + 20'(cfg.own_address[15:0])
          + 20'(req.dest_address[31:16]) + 20'(req.dest_address[15:0]);
      // two end-around carry folds bring a 20-bit sum down to 16 bits
      fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
      csum  = ~fold2;
      on_subnet = (req.dest_address & cfg.net_mask)
               == (cfg.own_address & cfg.net_mask);

      rsp.header_word0 = {VerIhlTos, total_len};
      rsp.header_word1 = {IdentWord, FlagsWord};
      rsp.header_word2 = {ttl_proto, csum};
      rsp.header_word3 = cfg.own_address;
      rsp.header_word4 = req.dest_address;
      rsp.next_hop     = on_subnet ? req.dest_address : cfg.gateway_address;
   end

endmodule
`default_nettype wire

// ----- dv/ipv4_header_builder_with_route_tb.sv -----
// Self-checking testbench for the IPv4 header builder with next-hop selection.
`default_nettype none
module ipv4_header_builder_with_route_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipv4hb_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrUnused = 2'd3;
   localparam int HoldCycles = 300;
   localparam int PhaseItems = 250;
   localparam int Phases     = 7;

   class header_ledger;
      logic [31:0]     own_addr;
      logic [31:0]     net_mask;
      logic [31:0]     gw_addr;
      rsp_payload_type headers_due[$];
      int              errors;

      function new();
         own_addr = '0;
         net_mask = '0;
         gw_addr  = '0;
         errors   = 0;
      endfunction

      function void write_register(logic [CsrIndexWidth-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_OWN_ADDRESS:     own_addr = value;
            CSR_NET_MASK:        net_mask = value;
            CSR_GATEWAY_ADDRESS: gw_addr  = value;
            default: ;
         endcase
      endfunction

      function rsp_payload_type build_header(req_payload_type r);
         rsp_payload_type h;
         logic [15:0]     total;
         logic [31:0]     sum;
         total = r.payload_length + 16'd20;
         sum = 32'h4500 + 32'(total) + 32'h0001 + 32'h4000 + {24'h40, r.protocol_number}
             + 32'(own_addr[31:16]) + 32'(own_addr[15:0])
             + 32'(r.dest_address[31:16]) + 32'(r.dest_address[15:0]);
         while (sum[31:16] != 16'h0)
            sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
         h.header_word0 = {16'h4500, total};
         h.header_word1 = 32'h0001_4000;
         h.header_word2 = {8'h40, r.protocol_number, ~sum[15:0]};
         h.header_word3 = own_addr;
         h.header_word4 = r.dest_address;
         h.next_hop     = ((r.dest_address & net_mask) == (own_addr & net_mask))
                          ? r.dest_address : gw_addr;
         return h;
      endfunction

      function void note_request(req_payload_type r);
         headers_due.push_back(build_header(r));
      endfunction

      function int pending();
         return headers_due.size();
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t %s mismatch: expected %08h actual %08h",
                     $realtime, field, want, got);
         end
      endfunction

      function void check_header(rsp_payload_type got);
         rsp_payload_type want;
         if (headers_due.size() == 0) begin
            errors++;
            $display("%0t unexpected header: expected none actual %h", $realtime, got);
            return;
         end
         want = headers_due.pop_front();
         compare_field("header_word0", want.header_word0, got.header_word0);
         compare_field("header_word1", want.header_word1, got.header_word1);
         compare_field("header_word2", want.header_word2, got.header_word2);
         compare_field("header_word3", want.header_word3, got.header_word3);
         compare_field("header_word4", want.header_word4, got.header_word4);
         compare_field("next_hop",     want.next_hop,     got.next_hop);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [31:0]              csr_data = '0;

   bit idle_on = 1'b1;
   bit long_hold = 1'b0;

   header_ledger ledger = new();

   ipv4_header_builder_with_route dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_header(rsp_data);
   end

   // result side back-pressure
   initial begin
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (idle_on ? $urandom_range(1, 15) : 1) @(posedge clock);
         end
      end
   end

   task automatic send_request(req_payload_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      ledger.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ledger.write_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] prefix_mask(int unsigned len);
      return ~(32'hFFFF_FFFF >> len);
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned     pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         r.dest_address = (ledger.own_addr & ledger.net_mask) | ($urandom & ~ledger.net_mask);
      else if (pick < 9)
         r.dest_address = $urandom;
      else
         r.dest_address = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      r.protocol_number = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 15);
      if (pick == 0)
         r.payload_length = 16'($urandom_range(65510, 65535));
      else if (pick == 1)
         r.payload_length = 16'($urandom_range(0, 8));
      else
         r.payload_length = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic set_phase_config(int phase);
      case (phase)
         0: begin
            write_csr(CSR_OWN_ADDRESS, $urandom);
            write_csr(CSR_NET_MASK, 32'h0);
            write_csr(CSR_GATEWAY_ADDRESS, $urandom);
         end
         1: begin
            write_csr(CSR_OWN_ADDRESS, 32'hFFFF_FFFF);
            write_csr(CSR_NET_MASK, 32'hFFFF_FFFF);
            write_csr(CSR_GATEWAY_ADDRESS, 32'h0);
         end
         3: begin
            write_csr(CSR_OWN_ADDRESS, 32'h0);
            write_csr(CSR_NET_MASK, prefix_mask($urandom_range(1, 31)));
            write_csr(CSR_GATEWAY_ADDRESS, 32'hFFFF_FFFF);
            write_csr(CsrUnused, $urandom);
         end
         4: begin
            write_csr(CSR_OWN_ADDRESS, $urandom);
            write_csr(CSR_NET_MASK, $urandom);
            write_csr(CSR_GATEWAY_ADDRESS, $urandom);
         end
         default: begin
            write_csr(CSR_OWN_ADDRESS, $urandom);
            write_csr(CSR_NET_MASK, prefix_mask($urandom_range(0, 32)));
            write_csr(CSR_GATEWAY_ADDRESS, $urandom);
         end
      endcase
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: /24 subnet, header field extremes, length wrap
      write_csr(CSR_OWN_ADDRESS, 32'hC0A8_010A);
      write_csr(CSR_NET_MASK, 32'hFFFF_FF00);
      write_csr(CSR_GATEWAY_ADDRESS, 32'hC0A8_0101);
      send_request('{32'hC0A8_0177, 8'd6,   16'd0});
      send_request('{32'h0808_0808, 8'd17,  16'd65515});
      send_request('{32'hC0A8_010A, 8'd1,   16'd1480});
      send_request('{32'h0000_0000, 8'd0,   16'd0});
      send_request('{32'hFFFF_FFFF, 8'd255, 16'hFFFF});
      send_request('{32'hC0A8_01FF, 8'd255, 16'd65516});
      send_request('{32'hC0A8_0200, 8'd6,   16'd65535});
      send_request('{32'h5555_AAAA, 8'hAA,  16'h5555});
      send_request('{32'hAAAA_5555, 8'h55,  16'hAAAA});
      drain();

      // zero mask: everything local
      write_csr(CSR_NET_MASK, 32'h0);
      send_request('{32'h0102_0304, 8'd6,  16'd100});
      send_request('{32'hFFFF_FFFF, 8'd17, 16'd65515});
      drain();

      // all-ones registers, then an out-of-range write
      write_csr(CSR_OWN_ADDRESS, 32'hFFFF_FFFF);
      write_csr(CSR_NET_MASK, 32'hFFFF_FFFF);
      write_csr(CSR_GATEWAY_ADDRESS, 32'hFFFF_FFFF);
      send_request('{32'hFFFF_FFFF, 8'd6, 16'd20});
      send_request('{32'hFFFF_FFFE, 8'd6, 16'd0});
      drain();
      write_csr(CsrUnused, 32'h1234_5678);
      send_request('{32'h0A00_0001, 8'd1, 16'd64});
      send_request('{32'hFFFF_FFFF, 8'd1, 16'd64});

      for (int phase = 0; phase < Phases; phase++) begin
         drain();
         set_phase_config(phase);
         idle_on = (phase != Phases - 1);
         if (phase == 2) begin
            idle_on   = 1'b0;
            long_hold = 1'b1;
         end
         repeat (PhaseItems) send_request(random_request());
      end

      drain();
      repeat (10) @(posedge clock);
      if (ledger.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/ipv4hb_pkg.sv
hdl/ipv4hb_csr.sv
hdl/ipv4hb_hdr.sv
hdl/ipv4_header_builder_with_route.sv
dv/ipv4_header_builder_with_route_tb.sv
